### rtl/vdu_pkg.sv
`timescale 1ns / 1ps

package vdu_pkg;

  // Element and result formats.
  localparam int ELEM_W      = 16;
  localparam int ACC_W       = 48;
  localparam int PROD_W      = 2 * ELEM_W;
  localparam int OUT_W       = 32;
  localparam int METRIC_W    = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 2;
  localparam int DOT_SHIFT   = 2 * ELEM_W - 18;

  // Iterative root and divide unit sizes.
  localparam int ROOT_IN_W   = 50;
  localparam int ROOT_W      = 25;
  localparam int NROOT_W     = 24;
  localparam int REM_W       = 49;
  localparam int RATIO_W     = 17;
  localparam int ROOT_STEPS  = 25;
  localparam int DIV_STEPS   = 17;
  localparam int CNT_W       = 5;
  localparam int QUEUE_DEPTH = 2;

  // Register map.
  localparam logic [CFG_ADDR_W-1:0] ADDR_METRIC = 2'd0;

  // Metric codes.
  localparam logic [METRIC_W-1:0] METRIC_L2     = 2'd0;
  localparam logic [METRIC_W-1:0] METRIC_INNER  = 2'd1;
  localparam logic [METRIC_W-1:0] METRIC_COSINE = 2'd2;
  localparam logic [METRIC_W-1:0] METRIC_NONE   = 2'd3;

  localparam logic [OUT_W-1:0] ONE_Q16 = 32'd65536;
  localparam logic [OUT_W-1:0] TWO_Q16 = 32'd131072;

  typedef struct packed {
    logic signed [ACC_W-1:0] dot;
    logic signed [ACC_W-1:0] left_sq;
    logic signed [ACC_W-1:0] right_sq;
    logic signed [ACC_W-1:0] diff_sq;
    logic [METRIC_W-1:0]     metric;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT_DIFF,
    ST_ROOT_LEFT,
    ST_ROOT_RIGHT,
    ST_MUL,
    ST_DIV_CHECK,
    ST_DIV,
    ST_DONE
  } state_t;

  // Saturating add of two accumulator-wide signed values.
  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] acc,
                                                      input logic signed [ACC_W-1:0] term);
    logic signed [ACC_W:0] s;
    s = {acc[ACC_W-1], acc} + {term[ACC_W-1], term};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s[ACC_W-1:0];
  endfunction

endpackage

### rtl/vdu_front.sv
`timescale 1ns / 1ps

module vdu_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  logic signed [vdu_pkg::ELEM_W-1:0]   left_element,
  input  logic signed [vdu_pkg::ELEM_W-1:0]   right_element,
  input  logic                                last_element,
  input  logic [vdu_pkg::METRIC_W-1:0]        metric,
  output logic                                q_push,
  output vdu_pkg::job_t                       q_job,
  input  logic                                q_full
);

  logic                                  s1_valid_r;
  logic                                  s1_last_r;
  logic signed [vdu_pkg::PROD_W-1:0]     p_dot_r;
  logic signed [vdu_pkg::PROD_W-1:0]     p_left_r;
  logic signed [vdu_pkg::PROD_W-1:0]     p_right_r;
  logic [vdu_pkg::PROD_W-1:0]            p_diff_r;
  logic signed [vdu_pkg::ACC_W-1:0]      dot_r, left_r, right_r, diff_r;
  logic signed [vdu_pkg::ACC_W-1:0]      dot_nxt, left_nxt, right_nxt, diff_nxt;
  logic signed [vdu_pkg::ELEM_W:0]       diff;
  logic signed [vdu_pkg::ELEM_W:0]       diff_abs;
  logic                                  stall;
  logic                                  accept;
  logic                                  advance;

  // A finished vector waits in the product stage while the queue is full.
  assign stall   = s1_valid_r & s1_last_r & q_full;
  assign full    = stall;
  assign accept  = push & ~stall;
  assign advance = s1_valid_r & ~stall;

  // Difference magnitude always fits the element width unsigned.
  assign diff     = {left_element[vdu_pkg::ELEM_W-1], left_element}
                  - {right_element[vdu_pkg::ELEM_W-1], right_element};
  assign diff_abs = diff[vdu_pkg::ELEM_W] ? -diff : diff;

  // Product stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!stall) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last_r <= last_element;
      p_dot_r   <= left_element * right_element;
      p_left_r  <= left_element * left_element;
      p_right_r <= right_element * right_element;
      p_diff_r  <= diff_abs[vdu_pkg::ELEM_W-1:0] * diff_abs[vdu_pkg::ELEM_W-1:0];
    end
  end

  // Running sums with saturation.
  assign dot_nxt   = vdu_pkg::sat_add(dot_r,
                       {{(vdu_pkg::ACC_W-vdu_pkg::PROD_W){p_dot_r[vdu_pkg::PROD_W-1]}}, p_dot_r});
  assign left_nxt  = vdu_pkg::sat_add(left_r,
                       {{(vdu_pkg::ACC_W-vdu_pkg::PROD_W){p_left_r[vdu_pkg::PROD_W-1]}}, p_left_r});
  assign right_nxt = vdu_pkg::sat_add(right_r,
                       {{(vdu_pkg::ACC_W-vdu_pkg::PROD_W){p_right_r[vdu_pkg::PROD_W-1]}},
                        p_right_r});
  assign diff_nxt  = vdu_pkg::sat_add(diff_r,
                       {{(vdu_pkg::ACC_W-vdu_pkg::PROD_W){1'b0}}, p_diff_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r   <= '0;
      left_r  <= '0;
      right_r <= '0;
      diff_r  <= '0;
    end else if (advance) begin
      if (s1_last_r) begin
        dot_r   <= '0;
        left_r  <= '0;
        right_r <= '0;
        diff_r  <= '0;
      end else begin
        dot_r   <= dot_nxt;
        left_r  <= left_nxt;
        right_r <= right_nxt;
        diff_r  <= diff_nxt;
      end
    end
  end

  // Hand the finished sums to the back end.
  assign q_push         = advance & s1_last_r;
  assign q_job.dot      = dot_nxt;
  assign q_job.left_sq  = left_nxt;
  assign q_job.right_sq = right_nxt;
  assign q_job.diff_sq  = diff_nxt;
  assign q_job.metric   = metric;

endmodule

### rtl/vdu_queue.sv
`timescale 1ns / 1ps

module vdu_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  vdu_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output vdu_pkg::job_t pop_job,
  output logic          empty
);

  localparam int PTR_W = $clog2(vdu_pkg::QUEUE_DEPTH);

  vdu_pkg::job_t                entry_r [vdu_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]             wr_ptr_r;
  logic [PTR_W-1:0]             rd_ptr_r;
  logic [PTR_W:0]               count_r;
  logic                         do_push;
  logic                         do_pop;

  assign full    = (count_r == (PTR_W+1)'(vdu_pkg::QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign pop_job = entry_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

### rtl/vdu_back.sv
`timescale 1ns / 1ps

module vdu_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_empty,
  input  vdu_pkg::job_t                  q_job,
  output logic                           q_pop,
  output logic                           out_empty,
  input  logic                           pop,
  output logic signed [vdu_pkg::OUT_W-1:0] out_value,
  output logic                           out_zero
);

  vdu_pkg::state_t                   state_r, state_nxt;
  logic [vdu_pkg::CNT_W-1:0]         cnt_r;
  logic [vdu_pkg::REM_W-1:0]         rem_r;
  logic [vdu_pkg::ROOT_W-1:0]        root_r;
  logic [vdu_pkg::ROOT_IN_W-1:0]     x_r;
  logic [vdu_pkg::ACC_W-1:0]         right_sq_r;
  logic [vdu_pkg::NROOT_W-1:0]       nl_r, nr_r;
  logic [vdu_pkg::ACC_W-1:0]         den_r;
  logic [vdu_pkg::ACC_W-1:0]         mag_r;
  logic                              neg_r;
  logic [vdu_pkg::RATIO_W-1:0]       q_r;
  logic [vdu_pkg::OUT_W-1:0]         val_r;
  logic                              zero_r;
  logic                              out_valid_r;
  logic [vdu_pkg::OUT_W-1:0]         out_val_r;
  logic                              out_zero_r;

  logic [vdu_pkg::REM_W-1:0]         root_sh, root_trial, root_rem;
  logic                              root_ge;
  logic [vdu_pkg::ROOT_W-1:0]        root_step;
  logic [vdu_pkg::REM_W-1:0]         div_sh, div_rem;
  logic                              div_ge;
  logic [vdu_pkg::RATIO_W-1:0]       q_step, ratio;
  logic                              last_root, last_div;
  logic                              out_free, out_load;
  logic                              cos_zero;
  logic                              too_big;
  logic signed [vdu_pkg::ACC_W-vdu_pkg::DOT_SHIFT-1:0] dot_sh;
  logic [vdu_pkg::OUT_W-1:0]         dot_val;
  logic [vdu_pkg::OUT_W-1:0]         cos_val;
  logic [vdu_pkg::ACC_W-1:0]         q_mag;

  // One root bit per cycle: bring down two radicand bits, try to subtract.
  assign root_sh    = {rem_r[vdu_pkg::REM_W-3:0], x_r[vdu_pkg::ROOT_IN_W-1 -: 2]};
  assign root_trial = {{(vdu_pkg::REM_W-vdu_pkg::ROOT_W-2){1'b0}}, root_r, 2'b01};
  assign root_ge    = root_sh >= root_trial;
  assign root_rem   = root_ge ? root_sh - root_trial : root_sh;
  assign root_step  = {root_r[vdu_pkg::ROOT_W-2:0], root_ge};
  assign last_root  = cnt_r == vdu_pkg::CNT_W'(vdu_pkg::ROOT_STEPS - 1);

  // One quotient bit per cycle; the only nonzero numerator bit left is the LSB of mag.
  assign div_sh   = {rem_r[vdu_pkg::REM_W-2:0], (cnt_r == '0) ? mag_r[0] : 1'b0};
  assign div_ge   = div_sh >= {1'b0, den_r};
  assign div_rem  = div_ge ? div_sh - {1'b0, den_r} : div_sh;
  assign q_step   = {q_r[vdu_pkg::RATIO_W-2:0], div_ge};
  assign last_div = cnt_r == vdu_pkg::CNT_W'(vdu_pkg::DIV_STEPS - 1);
  assign ratio    = (q_step > vdu_pkg::RATIO_W'(vdu_pkg::ONE_Q16)) ?
                    vdu_pkg::RATIO_W'(vdu_pkg::ONE_Q16) : q_step;
  assign cos_val  = neg_r ? vdu_pkg::ONE_Q16 + {{(vdu_pkg::OUT_W-vdu_pkg::RATIO_W){1'b0}}, ratio}
                          : vdu_pkg::ONE_Q16 - {{(vdu_pkg::OUT_W-vdu_pkg::RATIO_W){1'b0}}, ratio};

  // A quotient of two or more always clamps to one.
  assign too_big = {1'b0, mag_r} >= {den_r, 1'b0};

  // Inner product: floor shift to Q16.16, then saturate.
  assign dot_sh = q_job.dot[vdu_pkg::ACC_W-1:vdu_pkg::DOT_SHIFT];
  always_comb begin
    if (dot_sh > $signed({{(vdu_pkg::ACC_W-vdu_pkg::DOT_SHIFT-vdu_pkg::OUT_W+1){1'b0}},
                          {(vdu_pkg::OUT_W-1){1'b1}}})) begin
      dot_val = {1'b0, {(vdu_pkg::OUT_W-1){1'b1}}};
    end else if (dot_sh < $signed({{(vdu_pkg::ACC_W-vdu_pkg::DOT_SHIFT-vdu_pkg::OUT_W+1){1'b1}},
                                   {(vdu_pkg::OUT_W-1){1'b0}}})) begin
      dot_val = {1'b1, {(vdu_pkg::OUT_W-1){1'b0}}};
    end else begin
      dot_val = dot_sh[vdu_pkg::OUT_W-1:0];
    end
  end

  assign cos_zero = q_job.left_sq[vdu_pkg::ACC_W-1] | (q_job.left_sq == '0)
                  | q_job.right_sq[vdu_pkg::ACC_W-1] | (q_job.right_sq == '0);
  assign q_mag    = q_job.dot[vdu_pkg::ACC_W-1] ? -q_job.dot : q_job.dot;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vdu_pkg::ST_IDLE: begin
        if (!q_empty) begin
          priority if (q_job.metric == vdu_pkg::METRIC_L2) begin
            state_nxt = vdu_pkg::ST_ROOT_DIFF;
          end else if (q_job.metric == vdu_pkg::METRIC_COSINE && !cos_zero) begin
            state_nxt = vdu_pkg::ST_ROOT_LEFT;
          end else begin
            state_nxt = vdu_pkg::ST_DONE;
          end
        end
      end
      vdu_pkg::ST_ROOT_DIFF: begin
        if (last_root) state_nxt = vdu_pkg::ST_DONE;
      end
      vdu_pkg::ST_ROOT_LEFT: begin
        if (last_root) state_nxt = vdu_pkg::ST_ROOT_RIGHT;
      end
      vdu_pkg::ST_ROOT_RIGHT: begin
        if (last_root) state_nxt = vdu_pkg::ST_MUL;
      end
      vdu_pkg::ST_MUL: begin
        state_nxt = vdu_pkg::ST_DIV_CHECK;
      end
      vdu_pkg::ST_DIV_CHECK: begin
        state_nxt = too_big ? vdu_pkg::ST_DONE : vdu_pkg::ST_DIV;
      end
      vdu_pkg::ST_DIV: begin
        if (last_div) state_nxt = vdu_pkg::ST_DONE;
      end
      vdu_pkg::ST_DONE: begin
        if (out_free) state_nxt = vdu_pkg::ST_IDLE;
      end
      default: state_nxt = vdu_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    q_pop    = (state_r == vdu_pkg::ST_IDLE) & ~q_empty;
    out_free = ~out_valid_r | pop;
    out_load = (state_r == vdu_pkg::ST_DONE) & out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vdu_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath of the shared root and divide steps.
  always_ff @(posedge clk) begin
    unique case (state_r)
      vdu_pkg::ST_IDLE: begin
        cnt_r      <= '0;
        rem_r      <= '0;
        root_r     <= '0;
        mag_r      <= q_mag;
        neg_r      <= q_job.dot[vdu_pkg::ACC_W-1];
        right_sq_r <= q_job.right_sq;
        if (q_job.metric == vdu_pkg::METRIC_L2) begin
          x_r <= q_job.diff_sq[vdu_pkg::ACC_W-1] ? '0 : {q_job.diff_sq, 2'b00};
        end else begin
          x_r <= {2'b00, q_job.left_sq};
        end
        if (q_job.metric == vdu_pkg::METRIC_INNER) begin
          val_r  <= dot_val;
          zero_r <= 1'b0;
        end else if (q_job.metric == vdu_pkg::METRIC_COSINE && cos_zero) begin
          val_r  <= vdu_pkg::ONE_Q16;
          zero_r <= 1'b1;
        end else begin
          val_r  <= '0;
          zero_r <= 1'b0;
        end
      end
      vdu_pkg::ST_ROOT_DIFF, vdu_pkg::ST_ROOT_LEFT, vdu_pkg::ST_ROOT_RIGHT: begin
        cnt_r <= last_root ? '0 : cnt_r + 1'b1;
        if (last_root && state_r == vdu_pkg::ST_ROOT_LEFT) begin
          // Left root done: start over on the right norm.
          nl_r   <= root_step[vdu_pkg::NROOT_W-1:0];
          x_r    <= {2'b00, right_sq_r};
          rem_r  <= '0;
          root_r <= '0;
        end else begin
          rem_r  <= root_rem;
          root_r <= root_step;
          x_r    <= {x_r[vdu_pkg::ROOT_IN_W-3:0], 2'b00};
          if (last_root) begin
            if (state_r == vdu_pkg::ST_ROOT_DIFF) begin
              val_r <= {{(vdu_pkg::OUT_W-vdu_pkg::ROOT_W){1'b0}}, root_step};
            end else begin
              nr_r <= root_step[vdu_pkg::NROOT_W-1:0];
            end
          end
        end
      end
      vdu_pkg::ST_MUL: begin
        den_r <= nl_r * nr_r;
      end
      vdu_pkg::ST_DIV_CHECK: begin
        cnt_r <= '0;
        q_r   <= '0;
        rem_r <= {2'b00, mag_r[vdu_pkg::ACC_W-1:1]};
        if (too_big) begin
          val_r <= neg_r ? vdu_pkg::TWO_Q16 : '0;
        end
      end
      vdu_pkg::ST_DIV: begin
        rem_r <= div_rem;
        q_r   <= q_step;
        cnt_r <= cnt_r + 1'b1;
        if (last_div) begin
          val_r <= cos_val;
        end
      end
      vdu_pkg::ST_DONE: begin
        cnt_r <= '0;
      end
      default: begin
        cnt_r <= '0;
      end
    endcase
  end

  // One-entry result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_val_r  <= val_r;
      out_zero_r <= zero_r;
    end
  end

  assign out_empty = ~out_valid_r;
  assign out_value = out_val_r;
  assign out_zero  = out_zero_r;

endmodule

### rtl/vector_distance_unit.sv
`timescale 1ns / 1ps

// Vector distance unit. Element pairs (signed Q1.15) are taken one per cycle unless full is
// high and summed into dot product, both squared norms and squared difference; the pair
// marked last closes a vector and yields one signed Q16.16 result picked by the metric
// register (L2 distance, inner product or cosine distance). The summing front accepts a pair
// every cycle while not stalled; finished vectors wait in a two-entry queue for the back end,
// whose single shared root and divide datapath makes one bit per cycle. The input only stalls
// when two finished vectors are already waiting, so short vectors are paced by that datapath.
// Write the metric register only while no vector is in flight.
module vector_distance_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [vdu_pkg::ELEM_W-1:0]    in_left_element,
  input  logic signed [vdu_pkg::ELEM_W-1:0]    in_right_element,
  input  logic                                 in_last_element,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [vdu_pkg::OUT_W-1:0]     out_distance_value,
  output logic                                 out_zero_norm,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [vdu_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [vdu_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [vdu_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                 pready
);

  logic [vdu_pkg::METRIC_W-1:0] metric_r;
  logic                         q_push, q_full, q_pop, q_empty;
  vdu_pkg::job_t                q_in_job, q_out_job;

  // Configuration register.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metric_r <= vdu_pkg::METRIC_L2;
    end else if (psel && penable && pwrite && pready && paddr == vdu_pkg::ADDR_METRIC) begin
      metric_r <= pwdata[vdu_pkg::METRIC_W-1:0];
    end
  end

  assign prdata = (paddr == vdu_pkg::ADDR_METRIC) ?
                  {{(vdu_pkg::CFG_DATA_W-vdu_pkg::METRIC_W){1'b0}}, metric_r} : '0;

  vdu_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .left_element  (in_left_element),
    .right_element (in_right_element),
    .last_element  (in_last_element),
    .metric        (metric_r),
    .q_push        (q_push),
    .q_job         (q_in_job),
    .q_full        (q_full)
  );

  vdu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_in_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (q_out_job),
    .empty    (q_empty)
  );

  vdu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (q_out_job),
    .q_pop     (q_pop),
    .out_empty (empty),
    .pop       (pop),
    .out_value (out_distance_value),
    .out_zero  (out_zero_norm)
  );

  // A zero-norm flag always comes with a result of exactly one.
  a_zero_is_one: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_zero_norm) |-> (out_distance_value == $signed(vdu_pkg::ONE_Q16)))
    else $error("zero-norm result is not one");

  // Cosine results never leave the range zero to two.
  a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && metric_r == vdu_pkg::METRIC_COSINE) |->
      (out_distance_value >= 0 && out_distance_value <= $signed(vdu_pkg::TWO_Q16)))
    else $error("cosine result out of range");

  // The input only stalls while the queue to the back end is full.
  a_full_needs_queue: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> q_full)
    else $error("input stalled with queue space free");

  // The back end never takes a request from an empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue read while empty");

endmodule
